### sv/vwcp_pkg.sv
// ----------------------------------------------------------------------------
// Six-bit character packer package
// Shared constants, command/status types and the symbol encoding helpers.
// ----------------------------------------------------------------------------
package vwcp_pkg;

   localparam int unsigned CodeW  = 31;
   localparam int unsigned WidthW = 5;
   localparam int unsigned CharW  = 7;
   localparam int unsigned CountW = 5;
   localparam int unsigned SymW   = 6;

   localparam logic [WidthW-1:0] MinWidth   = 5'd8;
   localparam logic [WidthW-1:0] MaxWidth   = 5'd26;
   localparam logic [WidthW-1:0] ResetWidth = 5'd8;
   localparam logic [CountW-1:0] SymBits    = 5'd6;

   localparam logic [CharW-1:0] AsciiZero  = 7'h30;
   localparam logic [CharW-1:0] AsciiUpA   = 7'h41;
   localparam logic [CharW-1:0] AsciiLowA  = 7'h61;
   localparam logic [CharW-1:0] AsciiDash  = 7'h2D;
   localparam logic [CharW-1:0] AsciiUnder = 7'h5F;
   localparam logic [CharW-1:0] ErrorChar  = 7'h00;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // take the input word into the working state
      logic emit;    // move the next character into the output register
      logic finish;  // close the item, clearing the stream on a final word
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic has_char;  // at least one character of this item is still owed
      logic out_free;  // output register can take a character this cycle
   } dp_status_type;

   function automatic logic [WidthW-1:0] sat_width(input logic [WidthW-1:0] w);
      logic [WidthW-1:0] r;
      r = w;
      if (w < MinWidth) r = MinWidth;
      if (w > MaxWidth) r = MaxWidth;
      return r;
   endfunction

   function automatic logic [CharW-1:0] sym_to_ascii(input logic [SymW-1:0] v);
      logic [CharW-1:0] r;
      case (v) inside
         [6'd0:6'd9]:   r = AsciiZero + CharW'(v);
         [6'd10:6'd35]: r = AsciiUpA + CharW'(v) - 7'd10;
         [6'd36:6'd61]: r = AsciiLowA + CharW'(v) - 7'd36;
         6'd62:         r = AsciiDash;
         default:       r = AsciiUnder;
      endcase
      return r;
   endfunction

endpackage

### sv/vwcp_ctrl.sv
// ----------------------------------------------------------------------------
// Six-bit character packer controller
// Takes one input word at a time and steps the datapath through its characters.
// ----------------------------------------------------------------------------
module vwcp_ctrl
   import vwcp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!status.has_char) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/vwcp_datapath.sv
// ----------------------------------------------------------------------------
// Six-bit character packer datapath
// Bit accumulator, width register, character selection and output register.
// ----------------------------------------------------------------------------
module vwcp_datapath
   import vwcp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [WidthW-1:0]   csr_write_data,
   input  logic [CodeW-1:0]    req_code_value,
   input  logic                req_final_req,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CharW-1:0]    rsp_character,
   output logic                rsp_error,
   output logic                rsp_last
);

   logic [WidthW-1:0] width_ff, width_in;
   logic [CodeW-1:0]  acc_ff, acc_in;
   logic [CountW-1:0] cnt_ff, cnt_in;
   logic              hdr_sent_ff, hdr_sent_in;
   logic              hdr_pend_ff, hdr_pend_in;
   logic              fin_pend_ff, fin_pend_in;
   logic              err_pend_ff, err_pend_in;
   logic              valid_ff, valid_in;
   logic [CharW-1:0]  char_ff, char_in;
   logic              err_ff, err_in;
   logic              last_ff, last_in;

   logic [WidthW-1:0] eff_w;
   logic              code_nz;
   logic              code_err;
   logic              full_sym;
   logic              flush_sym;
   logic [CountW-1:0] cnt_less;
   logic              more_after_sym;

   assign eff_w     = sat_width(width_ff);
   assign code_nz   = (req_code_value != '0);
   assign code_err  = ((req_code_value >> eff_w) != '0);
   assign full_sym  = (cnt_ff >= SymBits);
   assign flush_sym = fin_pend_ff && (cnt_ff != '0);
   assign cnt_less  = cnt_ff - SymBits;
   // After a full symbol, is anything left to send for this word?
   assign more_after_sym = (cnt_less >= SymBits) || (fin_pend_ff && (cnt_less != '0));

   assign status.has_char = err_pend_ff || hdr_pend_ff || full_sym || flush_sym;
   assign status.out_free = !valid_ff || rsp_ready;

   always_comb begin
      width_in    = width_ff;
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      hdr_sent_in = hdr_sent_ff;
      hdr_pend_in = hdr_pend_ff;
      fin_pend_in = fin_pend_ff;
      err_pend_in = err_pend_ff;
      valid_in    = valid_ff;
      char_in     = char_ff;
      err_in      = err_ff;
      last_in     = last_ff;

      if (csr_write_enable) begin
         width_in = csr_write_data;
      end

      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end

      if (cmd.load) begin
         if (code_err) begin
            // A rejected word leaves the stream untouched.
            err_pend_in = 1'b1;
            fin_pend_in = 1'b0;
            hdr_pend_in = 1'b0;
         end else begin
            err_pend_in = 1'b0;
            fin_pend_in = req_final_req;
            hdr_pend_in = !hdr_sent_ff && (code_nz || req_final_req);
            hdr_sent_in = hdr_sent_ff || code_nz || req_final_req;
            if (code_nz) begin
               acc_in = acc_ff | (req_code_value << cnt_ff);
               cnt_in = cnt_ff + CountW'(eff_w);
            end
         end
      end

      if (cmd.emit) begin
         valid_in = 1'b1;
         err_in   = 1'b0;
         if (err_pend_ff) begin
            err_pend_in = 1'b0;
            char_in     = ErrorChar;
            err_in      = 1'b1;
            last_in     = 1'b1;
         end else if (hdr_pend_ff) begin
            hdr_pend_in = 1'b0;
            char_in     = sym_to_ascii(SymW'(eff_w));
            last_in     = !(full_sym || flush_sym);
         end else if (full_sym) begin
            char_in = sym_to_ascii(acc_ff[SymW-1:0]);
            acc_in  = acc_ff >> SymW;
            cnt_in  = cnt_less;
            last_in = !more_after_sym;
         end else begin
            char_in = sym_to_ascii(acc_ff[SymW-1:0]);
            acc_in  = '0;
            cnt_in  = '0;
            last_in = 1'b1;
         end
      end

      if (cmd.finish && fin_pend_ff) begin
         acc_in      = '0;
         cnt_in      = '0;
         hdr_sent_in = 1'b0;
         fin_pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= ResetWidth;
         acc_ff      <= '0;
         cnt_ff      <= '0;
         hdr_sent_ff <= 1'b0;
         hdr_pend_ff <= 1'b0;
         fin_pend_ff <= 1'b0;
         err_pend_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         width_ff    <= width_in;
         acc_ff      <= acc_in;
         cnt_ff      <= cnt_in;
         hdr_sent_ff <= hdr_sent_in;
         hdr_pend_ff <= hdr_pend_in;
         fin_pend_ff <= fin_pend_in;
         err_pend_ff <= err_pend_in;
         valid_ff    <= valid_in;
      end
      char_ff <= char_in;
      err_ff  <= err_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_character = char_ff;
   assign rsp_error     = err_ff;
   assign rsp_last      = last_ff;

endmodule

### sv/variable_width_six_bit_char_packer_core.sv
// ----------------------------------------------------------------------------
// Variable width six-bit character packer
// Packs codes of a programmable width into text characters, LSB first.
// ----------------------------------------------------------------------------
// One input word at a time is taken. Each word turns into zero to seven
// output characters (header, packed symbols, final flush), and the block
// sends at most one character per cycle, fewer while the output stalls.
// The next word is taken only once every character of the last one has
// moved into the output register. The output register lets a finished
// character wait while the next is built.
// ----------------------------------------------------------------------------
module variable_width_six_bit_char_packer_core
   import vwcp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [WidthW-1:0] csr_write_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CodeW-1:0]  req_code_value,
   input  logic              req_final_req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CharW-1:0]  rsp_character,
   output logic              rsp_error,
   output logic              rsp_last
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   vwcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   vwcp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_code_value   (req_code_value),
      .req_final_req    (req_final_req),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_character    (rsp_character),
      .rsp_error        (rsp_error),
      .rsp_last         (rsp_last)
   );

   // An error word always yields a single, closing, NUL (zero) character.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_last && (rsp_character == ErrorChar)))
      else $error("error word without last or with a nonzero character");

   // Only one word is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken again while a word is in work");

   // Characters are only produced while a word is in work.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!req_ready && status.has_char))
      else $error("character emitted with no word in work");

endmodule

### test/variable_width_six_bit_char_packer_core_test.sv
// ----------------------------------------------------------------------------
// Six-bit character packer testbench
// A directed script of words and width writes, then random streams of codes
// under random input gaps and output stalls. Every character is checked
// against a behavioral packer that runs as each word is accepted, or against the fixed record of a typed script row.
// ----------------------------------------------------------------------------
module variable_width_six_bit_char_packer_core_test;
   import vwcp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [CharW-1:0] character;
      logic             error;
      logic             last;
   } char_rec_type;

   typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [WidthW-1:0] width;
      logic [CodeW-1:0]  code;
      logic              fin;
      logic              typed;
      char_rec_type      want;
   } script_row_type;

   localparam char_rec_type NoRec      = '0;
   localparam char_rec_type BadCodeRec = '{ErrorChar, 1'b1, 1'b1};
   localparam char_rec_type Hdr8Rec    = '{7'h38, 1'b0, 1'b1};
   localparam char_rec_type Hdr26Rec   = '{7'h51, 1'b0, 1'b1};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_enable = 1'b0;
   logic [WidthW-1:0] csr_write_data = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [CodeW-1:0]  req_code_value = '0;
   logic              req_final_req = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [CharW-1:0]  rsp_character;
   logic              rsp_error;
   logic              rsp_last;

   // Packer state as the block should hold it.
   logic [WidthW-1:0] model_width = ResetWidth;
   logic [CodeW-1:0]  pack_acc = '0;
   int                pack_bits = 0;
   bit                hdr_done = 1'b0;

   string          sym_alphabet =
      "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-_";
   char_rec_type   expected_chars[$];
   script_row_type script[24];
   int             mismatches = 0;
   int             stall_left = 0;
   int             words_sent = 0;
   bit             steady_flow = 1'b0;

   variable_width_six_bit_char_packer_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_code_value   (req_code_value),
      .req_final_req    (req_final_req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_character    (rsp_character),
      .rsp_error        (rsp_error),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic int packing_width();
      if (model_width < MinWidth) return MinWidth;
      if (model_width > MaxWidth) return MaxWidth;
      return model_width;
   endfunction

   function automatic char_rec_type sym_char(input int v);
      char_rec_type rec;
      rec = NoRec;
      rec.character = 7'(sym_alphabet[v & 63]);
      return rec;
   endfunction

   function automatic void queue_char(input char_rec_type rec);
      expected_chars = {expected_chars, rec};
   endfunction

   // Works out the characters one word produces and advances the packer state.
   function automatic void pack_word(input logic [CodeW-1:0] code, input logic fin,
                                     input bit record);
      char_rec_type outq[$];
      int w;
      w = packing_width();
      if ((code >> w) != 0) begin
         if (record) queue_char(BadCodeRec);
         return;
      end
      if (!hdr_done && (code != 0 || fin)) begin
         outq = {outq, sym_char(w)};
         hdr_done = 1'b1;
      end
      if (code != 0) begin
         pack_acc = pack_acc | (code << pack_bits);
         pack_bits += w;
         while (pack_bits >= 6) begin
            outq = {outq, sym_char(pack_acc[5:0])};
            pack_acc = pack_acc >> 6;
            pack_bits -= 6;
         end
      end
      if (fin) begin
         if (pack_bits > 0) outq = {outq, sym_char(pack_acc[5:0])};
         pack_acc = '0;
         pack_bits = 0;
         hdr_done = 1'b0;
      end
      if (outq.size() > 0) outq[outq.size()-1].last = 1'b1;
      if (record) begin
         foreach (outq[i]) queue_char(outq[i]);
      end
   endfunction

   // Mostly no pause, some short ones and now and then a long one.
   function automatic int pause_len();
      int r;
      if (steady_flow) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 35);
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      $display("%0t mismatch: %s", $realtime, what);
   endtask

   task automatic send_word(input logic [CodeW-1:0] code, input logic fin,
                            input bit typed, input char_rec_type want);
      int gap;
      gap = pause_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_code_value <= code;
      req_final_req <= fin;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      pack_word(code, fin, !typed);
      if (typed) queue_char(want);
   endtask

   // A word that yields nothing may still be in flight when the queue drains.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_width(input logic [WidthW-1:0] w);
      csr_write_enable <= 1'b1;
      csr_write_data <= w;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_width = w;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
         stall_left = pause_len();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      char_rec_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            note_mismatch($sformatf("unexpected character %h", rsp_character));
         end else begin
            want = expected_chars.pop_front();
            if (rsp_character !== want.character)
               note_mismatch($sformatf("character %h, wanted %h", rsp_character,
                                       want.character));
            if (rsp_error !== want.error)
               note_mismatch($sformatf("error %b, wanted %b", rsp_error, want.error));
            if (rsp_last !== want.last)
               note_mismatch($sformatf("last %b, wanted %b", rsp_last, want.last));
         end
      end
   end

   initial begin
      logic [CodeW-1:0]  code;
      logic [WidthW-1:0] new_width;
      logic              fin;
      int                w;
      int                nb;
      int                span;
      int                r;

      script = '{
         '{ROW_WORD,  5'd0,  31'd0,          1'b0, 1'b0, NoRec},
         '{ROW_WORD,  5'd0,  31'd0,          1'b1, 1'b1, Hdr8Rec},
         '{ROW_WORD,  5'd0,  31'd256,        1'b0, 1'b1, BadCodeRec},
         '{ROW_WORD,  5'd0,  31'h7FFF_FFFF,  1'b1, 1'b1, BadCodeRec},
         '{ROW_WORD,  5'd0,  31'd255,        1'b0, 1'b0, NoRec},
         '{ROW_WORD,  5'd0,  31'd1,          1'b1, 1'b0, NoRec},
         '{ROW_WRITE, 5'd26, 31'd0,          1'b0, 1'b0, NoRec},
         '{ROW_WORD,  5'd0,  31'h03FF_FFFF,  1'b0, 1'b0, NoRec},
         '{ROW_WORD,  5'd0,  31'h0400_0000,  1'b0, 1'b1, BadCodeRec},
         '{ROW_WORD,  5'd0,  31'h02AA_AAAA,  1'b1, 1'b0, NoRec},
         '{ROW_WRITE, 5'd0,  31'd0,          1'b0, 1'b0, NoRec},
         '{ROW_WORD,  5'd0,  31'd0,          1'b1, 1'b1, Hdr8Rec},
         '{ROW_WORD,  5'd0,  31'd256,        1'b1, 1'b1, BadCodeRec},
         '{ROW_WRITE, 5'd31, 31'd0,          1'b0, 1'b0, NoRec},
         '{ROW_WORD,  5'd0,  31'd0,          1'b1, 1'b1, Hdr26Rec},
         '{ROW_WRITE, 5'd13, 31'd0,          1'b0, 1'b0, NoRec},
         '{ROW_WORD,  5'd0,  31'h1FFF,       1'b0, 1'b0, NoRec},
         '{ROW_WRITE, 5'd9,  31'd0,          1'b0, 1'b0, NoRec},
         '{ROW_WORD,  5'd0,  31'h1FF,        1'b0, 1'b0, NoRec},
         '{ROW_WORD,  5'd0,  31'd0,          1'b1, 1'b0, NoRec},
         '{ROW_WRITE, 5'd12, 31'd0,          1'b0, 1'b0, NoRec},
         '{ROW_WORD,  5'd0,  31'hFFE,        1'b0, 1'b0, NoRec},
         '{ROW_WORD,  5'd0,  31'd0,          1'b1, 1'b0, NoRec},
         '{ROW_WORD,  5'd0,  31'hFF,         1'b1, 1'b0, NoRec}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].kind == ROW_WRITE) begin
            wait_quiet();
            write_width(script[i].width);
         end else begin
            send_word(script[i].code, script[i].fin, script[i].typed, script[i].want);
         end
      end

      // Random streams, each under a fresh width and its own flow pattern.
      while (words_sent < 135) begin
         wait_quiet();
         r = $urandom_range(0, 9);
         if (r < 2)
            new_width = ($urandom_range(0, 1) == 0) ? MinWidth : MaxWidth;
         else if (r == 2)
            new_width = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 7))
                                                    : 5'($urandom_range(27, 31));
         else
            new_width = 5'($urandom_range(8, 26));
         write_width(new_width);
         steady_flow = ($urandom_range(0, 3) == 0);
         span = $urandom_range(6, 24);
         for (int k = 0; k < span; k++) begin
            w = packing_width();
            r = $urandom_range(0, 99);
            if (r < 4) begin
               code = 31'h1 << w;
            end else if (r < 9) begin
               code = 31'($urandom);
               if ((code >> w) == 0) code = code | (31'h1 << w);
            end else if (r < 17) begin
               code = '0;
            end else begin
               nb = $urandom_range(1, w);
               code = 31'($urandom) & ((31'h1 << nb) - 31'h1);
               if ($urandom_range(0, 3) == 0) code = code | (31'h1 << (w - 1));
            end
            fin = (k == span - 1) ? 1'($urandom_range(0, 1))
                                  : ($urandom_range(0, 9) == 0);
            send_word(code, fin, 1'b0, NoRec);
         end
      end

      wait_quiet();
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### sim.f
sv/vwcp_pkg.sv
sv/vwcp_ctrl.sv
sv/vwcp_datapath.sv
sv/variable_width_six_bit_char_packer_core.sv
test/variable_width_six_bit_char_packer_core_test.sv
